// ===== rtl/core/two_band_biquad_equalizer_macros.svh =====
// ----------------------------------------------------------------------------
// Equaliser assertion macros
// Shared concurrent assertion forms for the equaliser RTL.
// ----------------------------------------------------------------------------
`ifndef TWO_BAND_BIQUAD_EQUALIZER_MACROS_SVH
`define TWO_BAND_BIQUAD_EQUALIZER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define TBEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbeq: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define TBEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbeq: next-cycle check failed");

`endif

// ===== rtl/core/tbeq_pkg.sv =====
// ----------------------------------------------------------------------------
// Equaliser package
// Widths, constants and types shared by the two-band equaliser modules.
// ----------------------------------------------------------------------------
package tbeq_pkg;

  // Sample and coefficient formats
  localparam int SAMPLE_WIDTH    = 16;
  localparam int COEF_WIDTH      = 16;
  localparam int FRAC_BITS       = 14;
  localparam int FF_TAPS         = 3;
  localparam int FB_TAPS         = 2;
  localparam int NUM_TAPS        = FF_TAPS + FB_TAPS;

  // Serial MAC widths: five coefficients sum in COEF_WIDTH+3 bits, the
  // running upper part of the product needs one more
  localparam int PSUM_WIDTH      = COEF_WIDTH + 3;
  localparam int HI_WIDTH        = COEF_WIDTH + 4;
  localparam int ACC_WIDTH       = SAMPLE_WIDTH + HI_WIDTH;
  localparam int YFULL_WIDTH     = ACC_WIDTH - FRAC_BITS;
  localparam int CNT_WIDTH       = $clog2(SAMPLE_WIDTH);

  // Configuration port
  localparam int FF_WIDTH        = FF_TAPS * COEF_WIDTH;
  localparam int FB_WIDTH        = FB_TAPS * COEF_WIDTH;
  localparam int CFG_DATA_WIDTH  = FF_WIDTH;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [FF_WIDTH-1:0] FF_RESET = FF_WIDTH'(1 << FRAC_BITS);
  localparam logic [FB_WIDTH-1:0] FB_RESET = '0;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  // Rounding and saturation limits
  localparam logic signed [ACC_WIDTH-1:0] ROUND_HALF = ACC_WIDTH'(1 << (FRAC_BITS - 1));
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [YFULL_WIDTH-1:0] Y_MAX = YFULL_WIDTH'(SAMPLE_MAX);
  localparam logic signed [YFULL_WIDTH-1:0] Y_MIN = YFULL_WIDTH'(SAMPLE_MIN);

  // Coefficients, tap 0 in the low bits: b0, b1, b2, a1, a2
  typedef logic [NUM_TAPS-1:0][COEF_WIDTH-1:0] coef_vec_t;

  typedef struct packed {
    sample_t sample;
    logic    block_start;
  } in_item_t;

  typedef struct packed {
    sample_t filtered_sample;
    logic    clipped;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic last;
  } mac_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MAC,
    ST_ROUND
  } state_t;

  typedef enum logic {
    BAND_BASS,
    BAND_TREBLE
  } band_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_BASS_FF,
    CFG_BASS_FB,
    CFG_TREBLE_FF,
    CFG_TREBLE_FB
  } cfg_reg_t;

endpackage

// ===== rtl/core/two_band_biquad_equalizer.sv =====
// ----------------------------------------------------------------------------
// Two-band biquad equaliser
// Bass then treble direct form I biquad on 16-bit samples, Q2.14
// coefficients, round half up and saturate after each stage.
// ----------------------------------------------------------------------------
//  channel | direction | ports                              | item
//  --------+-----------+------------------------------------+-------------------
//  in      | input     | in_valid, in_ready, in_data        | sample, block_start
//  out     | output    | out_valid, out_ready, out_data     | filtered, clipped
//  cfg     | input     | cfg_valid, cfg_ready, cfg_index/data | register write
//
//  An item passes through the bass stage and then the treble stage before the
//  next accept: each stage is one load, SAMPLE_WIDTH serial MAC steps and one
//  round/saturate step through the single shared bit-serial MAC.
//  Reset restores the coefficient reset values and zeroes all history.
//  A finished item waits in the output register; the next item is accepted
//  meanwhile and only stalls at its final round cycle while out is full.
//  in_ready and cfg_ready are low in reset; cfg_ready is high otherwise.
// ----------------------------------------------------------------------------
`include "two_band_biquad_equalizer_macros.svh"

module two_band_biquad_equalizer
  import tbeq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  in_item_t                   in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output out_item_t                  out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  state_t state_r, state_nxt;
  band_t  band_r;
  logic [CNT_WIDTH-1:0] cnt_r;

  logic [FF_WIDTH-1:0] bass_ff_r, treble_ff_r;
  logic [FB_WIDTH-1:0] bass_fb_r, treble_fb_r;

  sample_t x_r;
  sample_t bass_xh0_r, bass_xh1_r, bass_yh0_r, bass_yh1_r;
  sample_t treble_xh0_r, treble_xh1_r, treble_yh0_r, treble_yh1_r;
  logic [SAMPLE_WIDTH-1:0] op_r [NUM_TAPS];
  logic clip_r;

  logic      out_valid_r;
  out_item_t out_item_r;

  logic      in_fire, out_fire, cnt_last, commit, treble_commit;
  mac_ctrl_t mac_ctrl;
  logic [NUM_TAPS-1:0] tap_bits;
  coef_vec_t coefs;

  logic signed [ACC_WIDTH-1:0]   acc, acc_rnd;
  logic signed [YFULL_WIDTH-1:0] y_full;
  logic    sat_hi, sat_lo;
  sample_t y_sat;

  assign in_fire       = in_valid && in_ready;
  assign out_fire      = out_valid_r && out_ready;
  assign cnt_last      = (cnt_r == CNT_WIDTH'(SAMPLE_WIDTH - 1));
  assign treble_commit = commit && (band_r == BAND_TREBLE);
  assign cfg_ready     = rst_n;
  assign out_valid     = out_valid_r;
  assign out_data      = out_item_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_MAC;
      ST_MAC:   if (cnt_last) state_nxt = ST_ROUND;
      ST_ROUND: begin
        if (commit) begin
          state_nxt = (band_r == BAND_BASS) ? ST_LOAD : ST_IDLE;
        end
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready       = 1'b0;
    mac_ctrl.clear = 1'b0;
    mac_ctrl.step  = 1'b0;
    mac_ctrl.last  = cnt_last;
    commit         = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready = rst_n;
      ST_LOAD:  mac_ctrl.clear = 1'b1;
      ST_MAC:   mac_ctrl.step = 1'b1;
      ST_ROUND: commit = (band_r == BAND_BASS) || !out_valid_r || out_ready;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Band select and bit counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      band_r <= BAND_BASS;
      cnt_r  <= '0;
    end else begin
      if (in_fire) begin
        band_r <= BAND_BASS;
      end else if (commit && band_r == BAND_BASS) begin
        band_r <= BAND_TREBLE;
      end
      if (mac_ctrl.clear) begin
        cnt_r <= '0;
      end else if (mac_ctrl.step) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bass_ff_r   <= FF_RESET;
      bass_fb_r   <= FB_RESET;
      treble_ff_r <= FF_RESET;
      treble_fb_r <= FB_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_BASS_FF:   bass_ff_r   <= cfg_data;
        CFG_BASS_FB:   bass_fb_r   <= cfg_data[FB_WIDTH-1:0];
        CFG_TREBLE_FF: treble_ff_r <= cfg_data;
        CFG_TREBLE_FB: treble_fb_r <= cfg_data[FB_WIDTH-1:0];
      endcase
    end
  end

  // Operand shift registers: loaded per stage, rotated LSB first
  always_ff @(posedge clk) begin
    if (mac_ctrl.clear) begin
      op_r[0] <= x_r;
      op_r[1] <= (band_r == BAND_BASS) ? bass_xh0_r : treble_xh0_r;
      op_r[2] <= (band_r == BAND_BASS) ? bass_xh1_r : treble_xh1_r;
      op_r[3] <= (band_r == BAND_BASS) ? bass_yh0_r : treble_yh0_r;
      op_r[4] <= (band_r == BAND_BASS) ? bass_yh1_r : treble_yh1_r;
    end else if (mac_ctrl.step) begin
      for (int k = 0; k < NUM_TAPS; k++) begin
        op_r[k] <= {op_r[k][0], op_r[k][SAMPLE_WIDTH-1:1]};
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_TAPS; k++) begin
      tap_bits[k] = op_r[k][0];
    end
    coefs = (band_r == BAND_BASS) ? coef_vec_t'({bass_fb_r, bass_ff_r})
                                  : coef_vec_t'({treble_fb_r, treble_ff_r});
  end

  tbeq_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (mac_ctrl),
    .tap_bits (tap_bits),
    .coefs    (coefs),
    .acc      (acc)
  );

  // Round half up, drop fraction, saturate
  always_comb begin
    acc_rnd = acc + ROUND_HALF;
    y_full  = acc_rnd[ACC_WIDTH-1:FRAC_BITS];
    sat_hi  = (y_full > Y_MAX);
    sat_lo  = (y_full < Y_MIN);
    if (sat_hi) begin
      y_sat = SAMPLE_MAX;
    end else if (sat_lo) begin
      y_sat = SAMPLE_MIN;
    end else begin
      y_sat = y_full[SAMPLE_WIDTH-1:0];
    end
  end

  // Stage input and clip flag
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r    <= in_data.sample;
      clip_r <= 1'b0;
    end else if (commit && band_r == BAND_BASS) begin
      x_r    <= y_sat;
      clip_r <= clip_r | sat_hi | sat_lo;
    end
  end

  // Filter history
  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_data.block_start)) begin
      bass_xh0_r   <= '0;
      bass_xh1_r   <= '0;
      bass_yh0_r   <= '0;
      bass_yh1_r   <= '0;
      treble_xh0_r <= '0;
      treble_xh1_r <= '0;
      treble_yh0_r <= '0;
      treble_yh1_r <= '0;
    end else if (commit) begin
      if (band_r == BAND_BASS) begin
        bass_xh1_r <= bass_xh0_r;
        bass_xh0_r <= x_r;
        bass_yh1_r <= bass_yh0_r;
        bass_yh0_r <= y_sat;
      end else begin
        treble_xh1_r <= treble_xh0_r;
        treble_xh0_r <= x_r;
        treble_yh1_r <= treble_yh0_r;
        treble_yh0_r <= y_sat;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (treble_commit) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (treble_commit) begin
      out_item_r.filtered_sample <= y_sat;
      out_item_r.clipped         <= clip_r | sat_hi | sat_lo;
    end
  end

  `TBEQ_ASSERT_NEXT(a_accept_loads, clk, rst_n, in_fire, state_r == ST_LOAD && band_r == BAND_BASS)
  `TBEQ_ASSERT_NEXT(a_last_rounds, clk, rst_n, state_r == ST_MAC && cnt_last, state_r == ST_ROUND)
  `TBEQ_ASSERT_NEXT(a_treble_emits, clk, rst_n, treble_commit, out_valid_r && state_r == ST_IDLE)

endmodule

// ===== rtl/core/tbeq_mac.sv =====
// ----------------------------------------------------------------------------
// Equaliser serial MAC
// Bit-serial five-tap multiply-accumulate, one operand bit per tap a cycle,
// LSB first; the sign bit is weighted negatively on the last step.
// ----------------------------------------------------------------------------
`include "two_band_biquad_equalizer_macros.svh"

module tbeq_mac
  import tbeq_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  mac_ctrl_t                   ctrl,
  input  logic [NUM_TAPS-1:0]         tap_bits,
  input  coef_vec_t                   coefs,
  output logic signed [ACC_WIDTH-1:0] acc
);

  logic signed [HI_WIDTH-1:0]   hi_r, hi_nxt;
  logic [SAMPLE_WIDTH-1:0]      lo_r, lo_nxt;
  logic signed [PSUM_WIDTH-1:0] psum;
  logic signed [PSUM_WIDTH-1:0] term;
  logic signed [HI_WIDTH:0]     t_sum;

  // Sum of the coefficients whose operand bit is set
  always_comb begin
    psum = '0;
    for (int k = 0; k < NUM_TAPS; k++) begin
      if (tap_bits[k]) begin
        psum = psum + PSUM_WIDTH'($signed(coefs[k]));
      end
    end
  end

  // Add at the current weight, then shift one bit out into the low word
  always_comb begin
    term   = ctrl.last ? -psum : psum;
    t_sum  = (HI_WIDTH+1)'(hi_r) + (HI_WIDTH+1)'(term);
    hi_nxt = t_sum[HI_WIDTH:1];
    lo_nxt = {t_sum[0], lo_r[SAMPLE_WIDTH-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r <= '0;
    end else if (ctrl.clear) begin
      hi_r <= '0;
    end else if (ctrl.step) begin
      hi_r <= hi_nxt;
    end
  end

  // Low word fills completely over one pass, no clear needed
  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      lo_r <= lo_nxt;
    end
  end

  assign acc = {hi_r, lo_r};

  `TBEQ_ASSERT_NEXT(a_mac_clear, clk, rst_n, ctrl.clear, hi_r == '0)

endmodule

// ===== verif/two_band_biquad_equalizer_tb.sv =====
// ----------------------------------------------------------------------------
// Two-band biquad equaliser testbench
// Drives samples through the bass and treble biquads under several
// coefficient sets and predicts every output item. The checks cover
// rounding, saturation in either band, feedback, history clearing and
// ignored upper register bits. Both handshakes idle at random, with
// some stretches where they do not idle at all.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_band_biquad_equalizer_tb
  import tbeq_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 48;
  localparam int PHASE_ITEMS    = 160;
  localparam int PHASES         = 12;

  localparam logic [FF_WIDTH-1:0] FF_UNITY = 48'h0000_0000_4000;
  localparam logic [FB_WIDTH-1:0] FB_NONE  = 32'h0000_0000;

  // How random coefficient sets are drawn
  typedef enum int {
    COEF_WILD,
    COEF_TAME,
    COEF_CORNER
  } coef_style_t;

  // One band's history: x1/y1 the most recent
  typedef struct packed {
    sample_t x1;
    sample_t x2;
    sample_t y1;
    sample_t y2;
  } band_hist_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  in_item_t                   in_data = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  out_item_t                  out_data;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

  // Coefficients and history as the block should hold them
  logic [FF_WIDTH-1:0] bass_ff_now = FF_RESET;
  logic [FB_WIDTH-1:0] bass_fb_now = FB_RESET;
  logic [FF_WIDTH-1:0] treble_ff_now = FF_RESET;
  logic [FB_WIDTH-1:0] treble_fb_now = FB_RESET;
  band_hist_t          bass_hist = '0;
  band_hist_t          treble_hist = '0;

  out_item_t pending_results[$];
  int        mismatch_count = 0;
  int        quiet_cycles = 0;
  bit        in_gaps_on = 1'b1;
  bit        out_stalls_on = 1'b1;

  two_band_biquad_equalizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Signed Q2.14 coefficient from a packed register word
  function automatic longint coef_of(input logic [FF_WIDTH-1:0] word, input int slot);
    logic signed [COEF_WIDTH-1:0] c;
    c = word[slot*COEF_WIDTH +: COEF_WIDTH];
    return longint'(c);
  endfunction

  // One direct form I band: feedback added, round half up, clamp
  function automatic sample_t biquad_band(input logic [FF_WIDTH-1:0] ff,
                                          input logic [FB_WIDTH-1:0] fb,
                                          input sample_t x,
                                          inout band_hist_t h,
                                          inout logic clip);
    longint acc;
    longint y;
    acc = coef_of(ff, 0) * longint'(x) + coef_of(ff, 1) * longint'(h.x1)
        + coef_of(ff, 2) * longint'(h.x2)
        + coef_of({16'h0000, fb}, 0) * longint'(h.y1)
        + coef_of({16'h0000, fb}, 1) * longint'(h.y2);
    y = (acc + 64'sd8192) >>> FRAC_BITS;
    if (y > longint'(SAMPLE_MAX)) begin
      y = longint'(SAMPLE_MAX);
      clip = 1'b1;
    end
    if (y < longint'(SAMPLE_MIN)) begin
      y = longint'(SAMPLE_MIN);
      clip = 1'b1;
    end
    h.x2 = h.x1;
    h.x1 = x;
    h.y2 = h.y1;
    h.y1 = sample_t'(y);
    return sample_t'(y);
  endfunction

  // Equalise one accepted item and queue the expected output
  task automatic equalize_sample(input in_item_t item);
    logic    clip;
    sample_t mid;
    sample_t y;
    clip = 1'b0;
    if (item.block_start) begin
      bass_hist   = '0;
      treble_hist = '0;
    end
    mid = biquad_band(bass_ff_now, bass_fb_now, item.sample, bass_hist, clip);
    y   = biquad_band(treble_ff_now, treble_fb_now, mid, treble_hist, clip);
    pending_results.push_back('{filtered_sample: y, clipped: clip});
  endtask

  // Send one item; valid stays high into the next item when no gap is drawn
  task automatic send_sample(input sample_t s, input logic start);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{sample: s, block_start: start};
    do @(posedge clk); while (!in_ready);
    equalize_sample('{sample: s, block_start: start});
  endtask

  // Stop sending and let every queued item come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // One register write; valid is left high for a following write
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_WIDTH-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BASS_FF:   bass_ff_now   = data[FF_WIDTH-1:0];
      CFG_BASS_FB:   bass_fb_now   = data[FB_WIDTH-1:0];
      CFG_TREBLE_FF: treble_ff_now = data[FF_WIDTH-1:0];
      default:       treble_fb_now = data[FB_WIDTH-1:0];
    endcase
  endtask

  // Load all four registers once the block is idle; feedback words carry
  // random junk above bit 31, which must be ignored
  task automatic load_coefficients(input logic [FF_WIDTH-1:0] bff, input logic [FB_WIDTH-1:0] bfb,
                                   input logic [FF_WIDTH-1:0] tff, input logic [FB_WIDTH-1:0] tfb);
    wait_drained();
    write_reg(CFG_BASS_FF, bff);
    write_reg(CFG_BASS_FB, {16'($urandom), bfb});
    write_reg(CFG_TREBLE_FF, tff);
    write_reg(CFG_TREBLE_FB, {16'($urandom), tfb});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [COEF_WIDTH-1:0] draw_coef(input coef_style_t style,
                                                      input bit feedback);
    logic [COEF_WIDTH-1:0] mag;
    case (style)
      COEF_WILD: return COEF_WIDTH'($urandom);
      COEF_TAME: begin
        mag = feedback ? COEF_WIDTH'($urandom_range(0, 16'h0C00))
                       : COEF_WIDTH'($urandom_range(0, 16'h4000));
        return $urandom_range(0, 1) ? -mag : mag;
      end
      default: begin
        case ($urandom_range(0, 4))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'h0000;
          3:       return 16'h4000;
          default: return 16'hC000;
        endcase
      end
    endcase
  endfunction

  function automatic sample_t draw_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return sample_t'(int'($urandom_range(0, 512)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Reset coefficients give a straight passthrough
  task automatic test_passthrough_extremes();
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b1);
    send_sample(-16'sd1, 1'b0);
    send_sample(sample_t'(16'h5555), 1'b0);
    send_sample(sample_t'(16'hAAAA), 1'b1);
  endtask

  // Half-up rounding, then clamping in each direction and in each band
  task automatic test_rounding_and_clamp();
    load_coefficients(48'h0000_0000_2000, FB_NONE, FF_UNITY, FB_NONE);
    send_sample(16'sd1, 1'b1);
    send_sample(-16'sd1, 1'b1);
    send_sample(16'sd3, 1'b1);
    send_sample(-16'sd3, 1'b1);
    load_coefficients(48'h0000_0000_7FFF, FB_NONE, FF_UNITY, FB_NONE);
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b1);
    load_coefficients(48'h0000_0000_8000, FB_NONE, FF_UNITY, FB_NONE);
    send_sample(SAMPLE_MIN, 1'b1);
    load_coefficients(FF_UNITY, FB_NONE, 48'h0000_0000_7FFF, FB_NONE);
    send_sample(16'sd20000, 1'b1);
  endtask

  // Full taps and feedback; a block start mid-stream drops the history
  task automatic test_feedback_and_clear();
    load_coefficients(48'h2000_2000_2000, 32'hE000_2000,
                      48'h0000_C000_4000, 32'h8000_7FFF);
    send_sample(16'sd10000, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(-16'sd20000, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd5000, 1'b1);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
  endtask

  // Random streams under random coefficient sets and idling patterns
  task automatic test_random_streams();
    int          phase;
    int          n;
    coef_style_t style;
    for (phase = 0; phase < PHASES; phase++) begin
      style = coef_style_t'(phase % 3);
      load_coefficients({draw_coef(style, 0), draw_coef(style, 0), draw_coef(style, 0)},
                        {draw_coef(style, 1), draw_coef(style, 1)},
                        {draw_coef(style, 0), draw_coef(style, 0), draw_coef(style, 0)},
                        {draw_coef(style, 1), draw_coef(style, 1)});
      in_gaps_on    = (phase % 4) != 1 && (phase % 4) != 3;
      out_stalls_on = (phase % 4) != 2 && (phase % 4) != 3;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_sample(draw_sample(), $urandom_range(0, 31) == 0);
      end
    end
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  // Result side: random stall before each item while stalls are on
  initial begin
    int stall;
    forever begin
      stall = out_stalls_on ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  // Compare each output item with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected output item: sample %0d clipped %0b",
                   $signed(out_data.filtered_sample), out_data.clipped);
      end else begin
        want = pending_results.pop_front();
        if (out_data.filtered_sample !== want.filtered_sample ||
            out_data.clipped !== want.clipped) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected sample %0d clipped %0b, got sample %0d clipped %0b",
                     $signed(want.filtered_sample), want.clipped,
                     $signed(out_data.filtered_sample), out_data.clipped);
        end
      end
    end
  end

  // Watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("two_band_biquad_equalizer verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_passthrough_extremes();
    test_rounding_and_clamp();
    test_feedback_and_clear();
    test_random_streams();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("two_band_biquad_equalizer verification clean");
    else
      $display("two_band_biquad_equalizer verification failed");
    $finish;
  end

endmodule
